[rtl/lbbt_pkg.sv]
// Shared types and constants of the label bounding box table.
// No dependencies; every other file of the block refers to this package.
package lbbt_pkg;

   // Width of the label field on the request and response channels.
   localparam int LABEL_W = 10;

   // Width of the mode field on the request channel.
   localparam int MODE_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_ACCUM = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // What the update stage asks of the rest of the pipeline for one request.
   typedef struct packed {
      logic wr_en;
      logic rsp_en;
   } ctl_type;

endpackage

[rtl/lbbt_channels.sv]
// Valid/ready channel interfaces of the label bounding box table.
// Depends on lbbt_pkg for the label and mode widths.
interface lbbt_req_if #(
   parameter int COORD_BITS = 12
);
   logic                          valid;
   logic                          ready;
   logic [lbbt_pkg::MODE_W-1:0]   mode;
   logic [lbbt_pkg::LABEL_W-1:0]  label;
   logic [COORD_BITS-1:0]         pos_x;
   logic [COORD_BITS-1:0]         pos_y;
   logic [COORD_BITS-1:0]         pos_z;

   modport source (output valid, output mode, output label, output pos_x, output pos_y,
                   output pos_z, input ready);
   modport sink (input valid, input mode, input label, input pos_x, input pos_y,
                 input pos_z, output ready);
endinterface

interface lbbt_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [lbbt_pkg::LABEL_W-1:0]  label_out;
   logic [COORD_BITS-1:0]         lo_x;
   logic [COORD_BITS-1:0]         lo_y;
   logic [COORD_BITS-1:0]         lo_z;
   logic [COORD_BITS-1:0]         hi_x;
   logic [COORD_BITS-1:0]         hi_y;
   logic [COORD_BITS-1:0]         hi_z;

   modport source (output valid, output found, output label_out, output lo_x, output lo_y,
                   output lo_z, output hi_x, output hi_y, output hi_z, input ready);
   modport sink (input valid, input found, input label_out, input lo_x, input lo_y,
                 input lo_z, input hi_x, input hi_y, input hi_z, output ready);
endinterface

[rtl/lbbt_merge.sv]
// Update stage of the label bounding box table: merges one request into a table entry
// and forms the query answer. Combinational; depends on lbbt_pkg.
module lbbt_merge #(
   parameter int COORD_BITS = 12
) (
   input  logic [lbbt_pkg::MODE_W-1:0] mode,
   input  logic                        label_nonzero,
   input  logic                        in_range,
   input  logic [3*COORD_BITS-1:0]     pos,
   input  logic [6*COORD_BITS:0]       entry_in,
   output lbbt_pkg::ctl_type           ctl,
   output logic [6*COORD_BITS:0]       entry_out,
   output logic                        found,
   output logic [6*COORD_BITS-1:0]     box_out
);

   localparam int BOX_W = 6 * COORD_BITS;

   logic              entry_valid;
   logic [BOX_W-1:0]  box_old;
   logic [BOX_W-1:0]  box_grown;
   logic [BOX_W-1:0]  box_point;

   assign entry_valid = entry_in[BOX_W];
   assign box_old     = entry_in[BOX_W-1:0];
   assign box_point   = {pos, pos};

   // The box holds the low corner x, y, z above the high corner x, y, z.
   for (genvar d = 0; d < 3; d++) begin : g_axis
      logic [COORD_BITS-1:0] p;
      logic [COORD_BITS-1:0] lo;
      logic [COORD_BITS-1:0] hi;
      assign p  = pos[(2-d)*COORD_BITS +: COORD_BITS];
      assign lo = box_old[(5-d)*COORD_BITS +: COORD_BITS];
      assign hi = box_old[(2-d)*COORD_BITS +: COORD_BITS];
      assign box_grown[(5-d)*COORD_BITS +: COORD_BITS] = (p < lo) ? p : lo;
      assign box_grown[(2-d)*COORD_BITS +: COORD_BITS] = (p > hi) ? p : hi;
   end

   always_comb begin
      ctl       = '0;
      entry_out = entry_in;
      found     = 1'b0;
      box_out   = '0;
      unique case (mode)
         lbbt_pkg::MODE_ACCUM: begin
            if (label_nonzero && in_range) begin
               ctl.wr_en = 1'b1;
               // A label without a live box starts over from this one point.
               entry_out = {1'b1, entry_valid ? box_grown : box_point};
            end
         end
         lbbt_pkg::MODE_QUERY: begin
            ctl.rsp_en = 1'b1;
            found      = in_range && entry_valid;
            box_out    = found ? box_old : '0;
         end
         lbbt_pkg::MODE_CLEAR: begin
            if (in_range) begin
               ctl.wr_en = 1'b1;
               entry_out = {1'b0, box_old};
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[rtl/label_bounding_box_table_top.sv]
// Label bounding box table. After reset the block sweeps its table once to drop every
// valid mark, one entry per cycle, and takes no request until the sweep ends. Then it
// accepts one request per cycle unless stalled: each request reads its entry from a single
// table RAM into a read register, is merged in the next cycle and written back, and a
// write to the same label in the cycle of the read is forwarded. A query answer is
// loaded into the output register when its request leaves the update stage; the input
// stalls only while a query waits behind an answer that has not been taken.
module label_bounding_box_table_top #(
   parameter int LABEL_COUNT = 1024,
   parameter int COORD_BITS  = 12
) (
   input  logic              clock,
   input  logic              reset,
   lbbt_req_if.sink          req_chan,
   lbbt_rsp_if.source        rsp_chan
);

   localparam int IDX_W   = $clog2(LABEL_COUNT);
   localparam int BOX_W   = 6 * COORD_BITS;
   localparam int ENTRY_W = BOX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LABEL_COUNT - 1);

   // Table RAM: valid mark on top of the box.
   logic [ENTRY_W-1:0] mem_ram [LABEL_COUNT];
   logic [ENTRY_W-1:0] rd_ff;

   logic                          clearing_ff, clearing_in;
   logic [IDX_W-1:0]              clr_idx_ff, clr_idx_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic [lbbt_pkg::MODE_W-1:0]   s1_mode_ff, s1_mode_in;
   logic [lbbt_pkg::LABEL_W-1:0]  s1_label_ff, s1_label_in;
   logic [IDX_W-1:0]              s1_idx_ff, s1_idx_in;
   logic [3*COORD_BITS-1:0]       s1_pos_ff, s1_pos_in;

   logic                          fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]              fwd_idx_ff, fwd_idx_in;
   logic [ENTRY_W-1:0]            fwd_entry_ff, fwd_entry_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [lbbt_pkg::LABEL_W-1:0]  rsp_label_ff, rsp_label_in;
   logic [BOX_W-1:0]              rsp_box_ff, rsp_box_in;

   logic               req_fire;
   logic [IDX_W-1:0]   req_idx;
   logic               s1_adv;
   logic               s1_in_range;
   logic [ENTRY_W-1:0] s1_entry;
   logic [ENTRY_W-1:0] s1_entry_new;
   logic               s1_found;
   logic [BOX_W-1:0]   s1_box;
   lbbt_pkg::ctl_type  s1_ctl;
   logic               upd_we;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   assign req_idx     = IDX_W'(req_chan.label);
   assign s1_in_range = 32'(s1_label_ff) < LABEL_COUNT;
   // The read of this request raced with the previous request's write back.
   assign s1_entry    = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_entry_ff : rd_ff;

   lbbt_merge #(
      .COORD_BITS (COORD_BITS)
   ) u_merge (
      .mode          (s1_mode_ff),
      .label_nonzero (s1_label_ff != '0),
      .in_range      (s1_in_range),
      .pos           (s1_pos_ff),
      .entry_in      (s1_entry),
      .ctl           (s1_ctl),
      .entry_out     (s1_entry_new),
      .found         (s1_found),
      .box_out       (s1_box)
   );

   assign s1_adv   = s1_valid_ff && !(s1_ctl.rsp_en && rsp_valid_ff && !rsp_chan.ready);
   assign upd_we   = s1_adv && s1_ctl.wr_en;
   assign req_chan.ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign mem_we    = clearing_ff || upd_we;
   assign mem_waddr = clearing_ff ? clr_idx_ff : s1_idx_ff;
   assign mem_wdata = clearing_ff ? '0 : s1_entry_new;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         if (clr_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_mode_in  = s1_mode_ff;
      s1_label_in = s1_label_ff;
      s1_idx_in   = s1_idx_ff;
      s1_pos_in   = s1_pos_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_idx_in   = fwd_idx_ff;
      fwd_entry_in = fwd_entry_ff;
      if (req_fire) begin
         s1_valid_in  = 1'b1;
         s1_mode_in   = req_chan.mode;
         s1_label_in  = req_chan.label;
         s1_idx_in    = req_idx;
         s1_pos_in    = {req_chan.pos_x, req_chan.pos_y, req_chan.pos_z};
         fwd_valid_in = upd_we;
         fwd_idx_in   = s1_idx_ff;
         fwd_entry_in = s1_entry_new;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_label_in = rsp_label_ff;
      rsp_box_in   = rsp_box_ff;
      if (s1_adv && s1_ctl.rsp_en) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = s1_found;
         rsp_label_in = s1_label_ff;
         rsp_box_in   = s1_box;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff   <= s1_mode_in;
      s1_label_ff  <= s1_label_in;
      s1_idx_ff    <= s1_idx_in;
      s1_pos_ff    <= s1_pos_in;
      fwd_idx_ff   <= fwd_idx_in;
      fwd_entry_ff <= fwd_entry_in;
      rsp_found_ff <= rsp_found_in;
      rsp_label_ff <= rsp_label_in;
      rsp_box_ff   <= rsp_box_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= mem_ram[req_idx];
      end
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.label_out = rsp_label_ff;
   assign rsp_chan.lo_x      = rsp_box_ff[5*COORD_BITS +: COORD_BITS];
   assign rsp_chan.lo_y      = rsp_box_ff[4*COORD_BITS +: COORD_BITS];
   assign rsp_chan.lo_z      = rsp_box_ff[3*COORD_BITS +: COORD_BITS];
   assign rsp_chan.hi_x      = rsp_box_ff[2*COORD_BITS +: COORD_BITS];
   assign rsp_chan.hi_y      = rsp_box_ff[1*COORD_BITS +: COORD_BITS];
   assign rsp_chan.hi_z      = rsp_box_ff[0 +: COORD_BITS];

`ifndef SYNTHESIS
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_chan.ready)
      else $error("request taken during the clearing sweep");

   a_query_lands_in_output: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_ctl.rsp_en) |=> (rsp_valid_ff && (rsp_label_ff == $past(s1_label_ff))))
      else $error("query answer did not reach the output register");

   a_stalled_read_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> ($stable(rd_ff) && $stable(s1_idx_ff) && !$past(mem_we)))
      else $error("stalled request lost its table read");

   a_found_needs_query: assert property (@(posedge clock) disable iff (reset)
      (s1_found && s1_valid_ff) |-> (s1_mode_ff == lbbt_pkg::MODE_QUERY))
      else $error("hit flagged for a request that is not a query");
`endif

endmodule
